// ===== rtl/core/ppm_pkg.sv =====
// Shared types, codes and constants of the pulse period power meter.
// No dependencies; every other file of the block but ppm_div imports this package.
package ppm_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;
  localparam logic CUR_SEL_RESET = 1'b1;
  localparam int EnergyDivisor = 1000000;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [2:0] {
    CMD_POWER_EDGE   = 3'd0,
    CMD_SECOND_EDGE  = 3'd1,
    CMD_READ         = 3'd2,
    CMD_SET_MODE     = 3'd3,
    CMD_RESET_ENERGY = 3'd4
  } cmd_code_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TIMEOUT     = 3'd0,
    CFG_CUR_SEL     = 3'd1,
    CFG_POWER_MULT  = 3'd2,
    CFG_VOLT_MULT   = 3'd3,
    CFG_CUR_MULT    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] timestamp_us;
    logic        want_current;
  } in_item_t;

  typedef struct packed {
    logic        select_level;
    logic        measuring_current;
    logic [15:0] power_w;
    logic [15:0] current_ca;
    logic [15:0] voltage_v;
    logic [31:0] energy_ws;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PDIV,
    ST_PWAIT,
    ST_CHECK1,
    ST_CDIV,
    ST_CWAIT,
    ST_CHECK2,
    ST_VDIV,
    ST_VWAIT,
    ST_EMUL,
    ST_EDIV,
    ST_EWAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_EXEC,
    DP_CHECK1,
    DP_CHECK2,
    DP_MUL,
    DP_HOLD
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_POWER,
    DIV_CURRENT,
    DIV_VOLTAGE,
    DIV_ENERGY
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    dp_op_t   op;
    logic     div_start;
    div_sel_t div_sel;
    logic     publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/ppm_div.sv =====
// Iterative restoring divider with a 16-bit saturating quotient, one quotient bit a cycle.
// Depends on nothing but its ports; used by ppm_datapath.
module ppm_div #(
  parameter int DEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [15:0]         quot
);

  localparam int CW = (DEN_BITS > 32) ? DEN_BITS : 32;
  localparam logic [4:0] STEPS = 5'd16;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [DEN_BITS-1:0] rem_r, rem_nxt;
  logic [15:0]         lo_r, lo_nxt;
  logic [15:0]         q_r, q_nxt;

  logic [CW-1:0]       hi_ext, den_ext;
  logic [DEN_BITS:0]   trial, diff;
  logic                fits;

  assign hi_ext  = CW'(num[31:16]);
  assign den_ext = CW'(den);
  assign trial   = {rem_r, lo_r[15]};
  assign fits    = trial >= {1'b0, den};
  assign diff    = trial - {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      if (den == '0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else if (hi_ext >= den_ext) begin
        // quotient does not fit: saturate
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        // upper half is the starting remainder, lower half shifts in
        rem_nxt  = hi_ext[DEN_BITS-1:0];
        lo_nxt   = num[15:0];
        q_nxt    = '0;
        cnt_nxt  = STEPS;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      lo_nxt  = {lo_r[14:0], 1'b0};
      q_nxt   = {q_r[14:0], fits};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/core/ppm_datapath.sv =====
// Datapath: configuration registers, meter state, energy scaling, divider, result register.
// Depends on ppm_pkg and ppm_div; driven by ppm_ctrl through ctrl_cmd_t.
module ppm_datapath
  import ppm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  in_item_t                in_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output out_item_t               out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_wdata
);

  localparam int TB   = TIME_BITS;
  localparam int TSW  = (TB < 32) ? TB : 32;
  localparam int CMPW = (TB > 32) ? TB : 32;

  // one million is 2^6 * 15625; the odd factor goes through a reciprocal,
  // floor(2^44 / 15625) + 1, exact for every 16-bit digit step
  localparam int          E_PRE_SHIFT   = 6;
  localparam int          E_RECIP_SHIFT = 44;
  localparam logic [31:0] E_RECIP       = 32'd1125899907;
  localparam logic [13:0] E_ODD         = 14'd15625;
  localparam logic [2:0]  E_DIGITS      = 3'd4;

  // configuration
  logic [31:0] timeout_r, pm_r, vm_r, cm_r;
  logic        csl_r;

  // captured request
  logic [2:0]    cmd_r;
  logic [TB-1:0] now_r;
  logic          want_r;

  // meter state
  logic [TB-1:0] lpe_r, lpe_nxt;
  logic [TB-1:0] pp_r, pp_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic [TB-1:0] lse_r, lse_nxt;
  logic [TB-1:0] wst_r, wst_nxt;
  logic [TB-1:0] cp_r, cp_nxt;
  logic [TB-1:0] vp_r, vp_nxt;
  logic          sel_r, sel_nxt;
  logic [15:0]   hp_r, hp_nxt;
  logic [15:0]   hc_r, hc_nxt;
  logic [15:0]   hv_r, hv_nxt;
  logic [31:0]   he_r, he_nxt;
  logic [63:0]   prod_r;

  logic          out_valid_r;
  out_item_t     out_data_r;

  // divider hookup
  logic          div_start, div_done;
  logic [31:0]   div_num;
  logic [15:0]   div_q;
  logic [TB-1:0] div_den;

  // energy scaling: long division by 15625 in 16-bit digits
  logic          e_start;
  logic          e_busy_r, e_busy_nxt;
  logic          e_phase_r, e_phase_nxt;
  logic          e_done_r, e_done_nxt;
  logic [2:0]    e_cnt_r, e_cnt_nxt;
  logic [63:0]   e_src_r, e_src_nxt;
  logic [13:0]   e_rem_r, e_rem_nxt;
  logic [15:0]   e_q_r, e_q_nxt;
  logic [63:0]   e_quo_r, e_quo_nxt;
  logic [31:0]   e_x, e_diff, e_sat;
  logic [63:0]   e_mul;

  function automatic logic is_stale(input logic [TB-1:0] now_t, input logic [TB-1:0] then_t,
                                    input logic [31:0] limit);
    logic [TB-1:0] d;
    d = now_t - then_t;
    return CMPW'(d) > CMPW'(limit);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      csl_r     <= CUR_SEL_RESET;
      pm_r      <= '0;
      vm_r      <= '0;
      cm_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:    timeout_r <= cfg_wdata;
        CFG_CUR_SEL:    csl_r     <= cfg_wdata[0];
        CFG_POWER_MULT: pm_r      <= cfg_wdata;
        CFG_VOLT_MULT:  vm_r      <= cfg_wdata;
        CFG_CUR_MULT:   cm_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_data.command;
      now_r  <= TB'(in_data.timestamp_us[TSW-1:0]);
      want_r <= in_data.want_current;
    end
    if (cmd.op == DP_MUL) begin
      prod_r <= 64'(cnt_r) * 64'(pm_r);
    end
  end

  always_comb begin
    logic [TB-1:0] pw;
    logic          do_check;
    lpe_nxt = lpe_r;
    pp_nxt  = pp_r;
    cnt_nxt = cnt_r;
    lse_nxt = lse_r;
    wst_nxt = wst_r;
    cp_nxt  = cp_r;
    vp_nxt  = vp_r;
    sel_nxt = sel_r;
    hp_nxt  = hp_r;
    hc_nxt  = hc_r;
    hv_nxt  = hv_r;
    he_nxt  = he_r;
    pw      = '0;
    do_check = (cmd.op == DP_CHECK2) || ((cmd.op == DP_CHECK1) && (hp_r != '0));

    case (cmd.op)
      DP_EXEC: begin
        case (cmd_r)
          CMD_POWER_EDGE: begin
            pp_nxt  = now_r - lpe_r;
            lpe_nxt = now_r;
            cnt_nxt = cnt_r + 32'd1;
          end
          CMD_SECOND_EDGE: begin
            if (is_stale(now_r, wst_r, timeout_r)) begin
              // no edge yet in this window: period unknown
              pw = (lse_r == wst_r) ? '0 : (now_r - lse_r);
              if (sel_r == csl_r) cp_nxt = pw;
              else vp_nxt = pw;
              sel_nxt = ~sel_r;
              wst_nxt = now_r;
            end
            lse_nxt = now_r;
          end
          CMD_READ: begin
            if (is_stale(now_r, lpe_r, timeout_r)) pp_nxt = '0;
          end
          CMD_SET_MODE: begin
            sel_nxt = want_r ? csl_r : ~csl_r;
            lse_nxt = now_r;
            wst_nxt = now_r;
          end
          CMD_RESET_ENERGY: begin
            cnt_nxt = '0;
          end
          default: ;
        endcase
      end
      DP_CHECK1, DP_CHECK2: begin
        if ((cmd.op == DP_CHECK1) && (hp_r == '0)) cp_nxt = '0;
        if (do_check && is_stale(now_r, lse_r, timeout_r)) begin
          // second output went quiet: drop its period and flip the select pin
          if (sel_r == csl_r) cp_nxt = '0;
          else vp_nxt = '0;
          sel_nxt = ~sel_r;
          lse_nxt = now_r;
          wst_nxt = now_r;
        end
      end
      DP_HOLD: begin
        case (cmd.div_sel)
          DIV_POWER:   hp_nxt = div_q;
          DIV_CURRENT: hc_nxt = div_q;
          DIV_VOLTAGE: hv_nxt = div_q;
          DIV_ENERGY:  he_nxt = e_sat;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpe_r <= '0;
      pp_r  <= '0;
      cnt_r <= '0;
      lse_r <= '0;
      wst_r <= '0;
      cp_r  <= '0;
      vp_r  <= '0;
      sel_r <= CUR_SEL_RESET;
      hp_r  <= '0;
      hc_r  <= '0;
      hv_r  <= '0;
      he_r  <= '0;
    end else begin
      lpe_r <= lpe_nxt;
      pp_r  <= pp_nxt;
      cnt_r <= cnt_nxt;
      lse_r <= lse_nxt;
      wst_r <= wst_nxt;
      cp_r  <= cp_nxt;
      vp_r  <= vp_nxt;
      sel_r <= sel_nxt;
      hp_r  <= hp_nxt;
      hc_r  <= hc_nxt;
      hv_r  <= hv_nxt;
      he_r  <= he_nxt;
    end
  end

  // operand select for the period divider
  always_comb begin
    div_num = pm_r;
    div_den = pp_r;
    case (cmd.div_sel)
      DIV_CURRENT: begin
        div_num = cm_r;
        div_den = cp_r;
      end
      DIV_VOLTAGE: begin
        div_num = vm_r;
        div_den = vp_r;
      end
      default: ;
    endcase
  end

  assign div_start = cmd.div_start && (cmd.div_sel != DIV_ENERGY);
  assign e_start   = cmd.div_start && (cmd.div_sel == DIV_ENERGY);

  ppm_div #(
    .DEN_BITS(TB)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done   (div_done),
    .quot   (div_q)
  );

  // each digit: multiply by the reciprocal, then take the remainder
  assign e_x    = {2'b00, e_rem_r, e_src_r[63:48]};
  assign e_mul  = 64'(e_x) * 64'(E_RECIP);
  assign e_diff = e_x - 32'(e_q_r) * 32'(E_ODD);
  assign e_sat  = (e_quo_r[63:32] != '0) ? '1 : e_quo_r[31:0];

  always_comb begin
    e_busy_nxt  = e_busy_r;
    e_phase_nxt = e_phase_r;
    e_done_nxt  = 1'b0;
    e_cnt_nxt   = e_cnt_r;
    e_src_nxt   = e_src_r;
    e_rem_nxt   = e_rem_r;
    e_q_nxt     = e_q_r;
    e_quo_nxt   = e_quo_r;
    if (e_start) begin
      e_src_nxt   = 64'(prod_r[63:E_PRE_SHIFT]);
      e_rem_nxt   = '0;
      e_quo_nxt   = '0;
      e_cnt_nxt   = E_DIGITS;
      e_phase_nxt = 1'b0;
      e_busy_nxt  = 1'b1;
    end else if (e_busy_r) begin
      if (!e_phase_r) begin
        e_q_nxt     = e_mul[E_RECIP_SHIFT +: 16];
        e_phase_nxt = 1'b1;
      end else begin
        e_rem_nxt   = e_diff[13:0];
        e_quo_nxt   = {e_quo_r[47:0], e_q_r};
        e_src_nxt   = {e_src_r[47:0], 16'b0};
        e_phase_nxt = 1'b0;
        e_cnt_nxt   = e_cnt_r - 3'd1;
        if (e_cnt_r == 3'd1) begin
          e_busy_nxt = 1'b0;
          e_done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_busy_r  <= 1'b0;
      e_phase_r <= 1'b0;
      e_done_r  <= 1'b0;
      e_cnt_r   <= '0;
    end else begin
      e_busy_r  <= e_busy_nxt;
      e_phase_r <= e_phase_nxt;
      e_done_r  <= e_done_nxt;
      e_cnt_r   <= e_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_src_r <= e_src_nxt;
    e_rem_r <= e_rem_nxt;
    e_q_r   <= e_q_nxt;
    e_quo_r <= e_quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r.select_level      <= sel_r;
      out_data_r.measuring_current <= (sel_r == csl_r);
      out_data_r.power_w           <= hp_r;
      out_data_r.current_ca        <= hc_r;
      out_data_r.voltage_v         <= hv_r;
      out_data_r.energy_ws         <= he_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.is_read  = (cmd_r == CMD_READ);
  assign status.div_done = div_done || e_done_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

// ===== rtl/core/ppm_ctrl.sv =====
// Controller state machine: sequences one request through update, divisions and result.
// Depends on ppm_pkg; commands ppm_datapath through ctrl_cmd_t.
module ppm_ctrl
  import ppm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = status.is_read ? ST_PDIV : ST_DONE;
      ST_PDIV:   state_nxt = ST_PWAIT;
      ST_PWAIT:  if (status.div_done) state_nxt = ST_CHECK1;
      ST_CHECK1: state_nxt = ST_CDIV;
      ST_CDIV:   state_nxt = ST_CWAIT;
      ST_CWAIT:  if (status.div_done) state_nxt = ST_CHECK2;
      ST_CHECK2: state_nxt = ST_VDIV;
      ST_VDIV:   state_nxt = ST_VWAIT;
      ST_VWAIT:  if (status.div_done) state_nxt = ST_EMUL;
      ST_EMUL:   state_nxt = ST_EDIV;
      ST_EDIV:   state_nxt = ST_EWAIT;
      ST_EWAIT:  if (status.div_done) state_nxt = ST_DONE;
      ST_DONE:   if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture   = 1'b0;
    cmd.op        = DP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DIV_POWER;
    cmd.publish   = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC:   cmd.op = DP_EXEC;
      ST_PDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_POWER;
      end
      ST_PWAIT: begin
        cmd.div_sel = DIV_POWER;
        if (status.div_done) cmd.op = DP_HOLD;
      end
      ST_CHECK1: cmd.op = DP_CHECK1;
      ST_CDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CURRENT;
      end
      ST_CWAIT: begin
        cmd.div_sel = DIV_CURRENT;
        if (status.div_done) cmd.op = DP_HOLD;
      end
      ST_CHECK2: cmd.op = DP_CHECK2;
      ST_VDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VOLTAGE;
      end
      ST_VWAIT: begin
        cmd.div_sel = DIV_VOLTAGE;
        if (status.div_done) cmd.op = DP_HOLD;
      end
      ST_EMUL:   cmd.op = DP_MUL;
      ST_EDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ENERGY;
      end
      ST_EWAIT: begin
        cmd.div_sel = DIV_ENERGY;
        if (status.div_done) cmd.op = DP_HOLD;
      end
      // hold the result until the output register frees up
      ST_DONE:   cmd.publish = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/pulse_period_power_meter.sv =====
// Pulse period power meter: one request in, one result out, one request at a time.
// Requests other than a read run the update and then publish a result; a read also
// runs the power, current and voltage divisions (one quotient bit a cycle) and the
// energy scaling (four reciprocal digit steps) first. A new request is taken only once
// the last result is in the output register. Reset (synchronous, rst_n low): meter state
// and results clear, select pin goes to the current level, configuration takes defaults.
module pulse_period_power_meter
  import ppm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ppm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ppm_datapath #(
    .TIME_BITS(TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== test/testbench.sv =====
// Testbench of pulse_period_power_meter: a directed table, then random phases of requests.
// Results are checked against the table or an in-bench model; needs ppm_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import ppm_pkg::*;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
  localparam int RAND_ITEMS = 850;
  localparam int PHASES = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 100;
  localparam int STUCK_LIMIT = 2000;
  localparam int REPORT_MAX = 10;
  localparam out_item_t RESET_VIEW = '{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 32'd0};

  typedef struct {
    logic        is_cfg;
    cfg_reg_t    reg_idx;
    logic [31:0] value;
    in_item_t    req;
    logic        has_exp;
    out_item_t   exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Model copy of the configuration and meter state
  logic [31:0] m_timeout, m_pmult, m_vmult, m_cmult;
  logic        m_cur_sel;
  logic [31:0] st_pwr_edge, st_pwr_period, st_pulses, st_cf1_edge, st_window;
  logic [31:0] st_cur_period, st_volt_period;
  logic        st_select;
  logic [15:0] held_power, held_current, held_voltage;
  logic [31:0] held_energy;

  out_item_t   results_due[$];
  stim_row_t   rows[$];
  int          mismatch_count = 0;
  int          stuck_cycles = 0;
  logic        calm = 1'b0;

  pulse_period_power_meter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] age_of(input logic [31:0] now, input logic [31:0] then_ts);
    return now - then_ts;
  endfunction

  function automatic logic [15:0] quotient16(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] q;
    if (den == 32'd0) return 16'd0;
    q = num / den;
    return (q > 32'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic stim_row_t req_row(input logic [2:0] cmd, input logic [31:0] ts,
                                        input logic want);
    stim_row_t r;
    r = '{1'b0, CFG_TIMEOUT, 32'd0, '{cmd, ts, want}, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_t idx, input logic [31:0] val);
    stim_row_t r;
    r = '{1'b1, idx, val, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic logic [31:0] pick_mult();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 5000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic meter_reset();
    m_timeout = TIMEOUT_RESET;
    m_cur_sel = CUR_SEL_RESET;
    m_pmult = '0;
    m_vmult = '0;
    m_cmult = '0;
    st_pwr_edge = '0;
    st_pwr_period = '0;
    st_pulses = '0;
    st_cf1_edge = '0;
    st_window = '0;
    st_cur_period = '0;
    st_volt_period = '0;
    st_select = CUR_SEL_RESET;
    held_power = '0;
    held_current = '0;
    held_voltage = '0;
    held_energy = '0;
  endtask

  // A silent second output drops the measured period and swaps the quantity.
  task automatic recheck_cf1(input logic [31:0] now);
    if (age_of(now, st_cf1_edge) > m_timeout) begin
      if (st_select == m_cur_sel) st_cur_period = '0;
      else st_volt_period = '0;
      st_select = ~st_select;
      st_cf1_edge = now;
      st_window = now;
    end
  endtask

  task automatic advance_meter(input in_item_t req, output out_item_t res);
    logic [31:0] now;
    logic [31:0] pw;
    logic [63:0] product;
    now = req.timestamp_us;
    case (req.command)
      CMD_POWER_EDGE: begin
        st_pwr_period = age_of(now, st_pwr_edge);
        st_pwr_edge = now;
        st_pulses = st_pulses + 32'd1;
      end
      CMD_SECOND_EDGE: begin
        if (age_of(now, st_window) > m_timeout) begin
          // no edge since the window opened means no period yet
          pw = (st_cf1_edge == st_window) ? 32'd0 : age_of(now, st_cf1_edge);
          if (st_select == m_cur_sel) st_cur_period = pw;
          else st_volt_period = pw;
          st_select = ~st_select;
          st_window = now;
        end
        st_cf1_edge = now;
      end
      CMD_READ: begin
        if (age_of(now, st_pwr_edge) > m_timeout) st_pwr_period = '0;
        held_power = quotient16(m_pmult, st_pwr_period);
        if (held_power == 16'd0) st_cur_period = '0;
        else recheck_cf1(now);
        held_current = quotient16(m_cmult, st_cur_period);
        recheck_cf1(now);
        held_voltage = quotient16(m_vmult, st_volt_period);
        product = 64'(st_pulses) * 64'(m_pmult);
        product = product / 64'(EnergyDivisor);
        held_energy = (product > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : product[31:0];
      end
      CMD_SET_MODE: begin
        st_select = req.want_current ? m_cur_sel : ~m_cur_sel;
        st_cf1_edge = now;
        st_window = now;
      end
      CMD_RESET_ENERGY: st_pulses = '0;
      default: ;
    endcase
    res.select_level = st_select;
    res.measuring_current = (st_select == m_cur_sel);
    res.power_w = held_power;
    res.current_ca = held_current;
    res.voltage_v = held_voltage;
    res.energy_ws = held_energy;
  endtask

  // Hold valid across requests when there is no gap, so it gets one assignment per step.
  task automatic send_req(input in_item_t req, input logic has_exp, input out_item_t exp);
    int gap;
    out_item_t pred;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    advance_meter(req, pred);
    results_due.push_back(has_exp ? exp : pred);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIMEOUT:    m_timeout = val;
      CFG_CUR_SEL:    m_cur_sel = val[0];
      CFG_POWER_MULT: m_pmult = val;
      CFG_VOLT_MULT:  m_vmult = val;
      CFG_CUR_MULT:   m_cmult = val;
      default: ;
    endcase
  endtask

  // Result side: stall a random number of cycles before each result.
  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("unexpected result: got %p", out_data);
        mismatch_count++;
      end else begin
        exp = results_due.pop_front();
        if (out_data.select_level !== exp.select_level ||
            out_data.measuring_current !== exp.measuring_current ||
            out_data.power_w !== exp.power_w ||
            out_data.current_ca !== exp.current_ca ||
            out_data.voltage_v !== exp.voltage_v ||
            out_data.energy_ws !== exp.energy_ws) begin
          if (mismatch_count < REPORT_MAX)
            $display("mismatch: exp sel=%0d cur=%0d p=%0d i=%0d v=%0d e=%0d, got sel=%0d cur=%0d p=%0d i=%0d v=%0d e=%0d",
                     exp.select_level, exp.measuring_current, exp.power_w,
                     exp.current_ca, exp.voltage_v, exp.energy_ws,
                     out_data.select_level, out_data.measuring_current, out_data.power_w,
                     out_data.current_ca, out_data.voltage_v, out_data.energy_ws);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [31:0] now;
    logic [31:0] step_max;
    logic [2:0]  cmd;
    int          roll;
    meter_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults first, then extremes of the multipliers and the timeout.
    rows.push_back(req_row(CMD_READ, 32'd0, 1'b0));
    rows[$].has_exp = 1'b1;
    rows[$].exp = RESET_VIEW;
    rows.push_back(req_row(CMD_SPARE_FIRST, 32'hFFFF_FFFF, 1'b1));
    rows[$].has_exp = 1'b1;
    rows[$].exp = RESET_VIEW;
    rows.push_back(req_row(CMD_SPARE_LAST, 32'd0, 1'b0));
    rows[$].has_exp = 1'b1;
    rows[$].exp = RESET_VIEW;
    rows.push_back(cfg_row(CFG_POWER_MULT, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(CFG_VOLT_MULT, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(CFG_CUR_MULT, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(CFG_TIMEOUT, 32'd1000));
    rows.push_back(req_row(CMD_POWER_EDGE, 32'd100, 1'b0));
    rows.push_back(req_row(CMD_POWER_EDGE, 32'd101, 1'b1));
    rows.push_back(req_row(CMD_SECOND_EDGE, 32'd200, 1'b0));
    rows.push_back(req_row(CMD_SECOND_EDGE, 32'd1500, 1'b0));
    rows.push_back(req_row(CMD_SECOND_EDGE, 32'd1600, 1'b1));
    rows.push_back(req_row(CMD_SECOND_EDGE, 32'd2600, 1'b0));
    rows.push_back(req_row(CMD_POWER_EDGE, 32'd2650, 1'b0));
    rows.push_back(req_row(CMD_READ, 32'd2700, 1'b0));
    rows.push_back(req_row(CMD_SET_MODE, 32'd2800, 1'b0));
    rows.push_back(req_row(CMD_SET_MODE, 32'd2900, 1'b1));
    rows.push_back(req_row(CMD_READ, 32'd5000, 1'b1));
    rows.push_back(req_row(CMD_RESET_ENERGY, 32'd0, 1'b1));
    rows.push_back(req_row(CMD_SPARE_FIRST + 3'd1, 32'h5555_AAAA, 1'b1));
    rows.push_back(req_row(CMD_READ, 32'hFFFF_FFFF, 1'b0));
    rows.push_back(cfg_row(CFG_CUR_SEL, 32'd0));
    rows.push_back(req_row(CMD_POWER_EDGE, 32'd0, 1'b0));
    rows.push_back(req_row(CMD_READ, 32'd0, 1'b1));
    rows.push_back(cfg_row(CFG_TIMEOUT, 32'hFFFF_FFFF));
    rows.push_back(req_row(CMD_POWER_EDGE, 32'd10, 1'b0));
    rows.push_back(req_row(CMD_POWER_EDGE, 32'hFFFF_FFFF, 1'b0));
    rows.push_back(req_row(CMD_READ, 32'd5, 1'b0));
    rows.push_back(cfg_row(CFG_TIMEOUT, 32'd0));
    rows.push_back(req_row(CMD_SECOND_EDGE, 32'd6, 1'b1));
    rows.push_back(req_row(CMD_READ, 32'd7, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].reg_idx, rows[i].value);
      else send_req(rows[i].req, rows[i].has_exp, rows[i].exp);
    end

    // Random phases: new settings each time, mostly plausible pulse traffic.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 4))
        0: write_reg(CFG_TIMEOUT, 32'd0);
        1: write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        2: write_reg(CFG_TIMEOUT, $urandom_range(1, 5000));
        3: write_reg(CFG_TIMEOUT, TIMEOUT_RESET);
        default: write_reg(CFG_TIMEOUT, $urandom_range(1000, 2000000));
      endcase
      write_reg(CFG_CUR_SEL, 32'($urandom_range(0, 1)));
      write_reg(CFG_POWER_MULT, pick_mult());
      write_reg(CFG_VOLT_MULT, pick_mult());
      write_reg(CFG_CUR_MULT, pick_mult());
      case ($urandom_range(0, 3))
        0: step_max = 32'd64;
        1: step_max = 32'd4096;
        2: step_max = 32'd300000;
        default: step_max = 32'd3000000;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      now = $urandom;
      for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) cmd = CMD_POWER_EDGE;
        else if (roll < 70) cmd = CMD_SECOND_EDGE;
        else if (roll < 85) cmd = CMD_READ;
        else if (roll < 92) cmd = CMD_SET_MODE;
        else if (roll < 95) cmd = CMD_RESET_ENERGY;
        else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        roll = $urandom_range(0, 99);
        if (roll < 75) now = now + $urandom_range(1, step_max);
        else if (roll < 92 && roll >= 82) now = now + m_timeout + $urandom_range(1, step_max);
        else if (roll >= 92) now = $urandom;
        send_req('{cmd, now, 1'($urandom_range(0, 1))}, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ppm_pkg.sv
rtl/core/ppm_div.sv
rtl/core/ppm_datapath.sv
rtl/core/ppm_ctrl.sv
rtl/core/pulse_period_power_meter.sv
test/testbench.sv
